// File: hdl/bpt_pkg.sv
// ============================================================================
// bpt_pkg: shared types and constants of the Bezier path tessellator
// Holds the micro-operation encoding that the controller issues to the
// datapath, the command and status structures, and the fixed constants.
// ============================================================================
package bpt_pkg;

    localparam int MAX_SAMPLES  = 64;
    localparam int CNT_W        = 6;
    localparam int STEP_W       = 5;
    localparam int MAX_STEPS    = 22;
    localparam int CFG_ADDR_W   = 2;
    localparam int T_STEP_RESET = 1311;
    localparam logic [1:0] CURVE_DEGREE_RESET = 2'd1;

    localparam logic [1:0] DEG_LINEAR    = 2'd1;
    localparam logic [1:0] DEG_QUADRATIC = 2'd2;
    localparam logic [1:0] DEG_CUBIC     = 2'd3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CURVE_DEGREE = 2'd0,
        CFG_T_STEP       = 2'd1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        A_U,
        A_T,
        A_PX,
        A_PY
    } a_sel_t;

    typedef enum logic [2:0] {
        B_ONE,
        B_U,
        B_T,
        B_UU,
        B_TT,
        B_WLO,
        B_WHI
    } b_sel_t;

    typedef enum logic [3:0] {
        D_NONE,
        D_UU,
        D_TT,
        D_W,
        D_W2,
        D_W3,
        D_ACCX_LO,
        D_ACCX_HI,
        D_ACCY_LO,
        D_ACCY_HI
    } dst_t;

    typedef struct packed {
        a_sel_t     a_sel;
        b_sel_t     b_sel;
        logic [1:0] idx;
        dst_t       dst;
        logic       last;
    } mop_t;

    typedef struct packed {
        logic accept;
        logic setup;
        logic op_valid;
        mop_t op;
        logic load_out;
    } bpt_cmd_t;

    typedef struct packed {
        logic       seg_go;
        logic [1:0] deg;
        logic       last_sample;
    } bpt_sts_t;

    // Weight steps first, then four product steps per control point.
    function automatic mop_t micro_op(input logic [1:0] deg, input logic [STEP_W-1:0] step);
        mop_t              op;
        logic [STEP_W-1:0] base;
        logic [STEP_W-1:0] k;
        op.a_sel = A_U;
        op.b_sel = B_ONE;
        op.idx   = 2'd0;
        op.dst   = D_NONE;
        op.last  = 1'b0;
        case (deg)
            DEG_QUADRATIC: base = STEP_W'(3);
            DEG_CUBIC:     base = STEP_W'(6);
            default:       base = STEP_W'(2);
        endcase
        k = step - base;
        if (step < base) begin
            case (deg)
                DEG_QUADRATIC: begin
                    case (step[1:0])
                        2'd0:    begin op.a_sel = A_U; op.b_sel = B_U; op.dst = D_W;
                                       op.idx = 2'd0; end
                        2'd1:    begin op.a_sel = A_T; op.b_sel = B_T; op.dst = D_W;
                                       op.idx = 2'd2; end
                        default: begin op.a_sel = A_U; op.b_sel = B_T; op.dst = D_W2;
                                       op.idx = 2'd1; end
                    endcase
                end
                DEG_CUBIC: begin
                    case (step[2:0])
                        3'd0:    begin op.a_sel = A_U; op.b_sel = B_U; op.dst = D_UU; end
                        3'd1:    begin op.a_sel = A_T; op.b_sel = B_T; op.dst = D_TT; end
                        3'd2:    begin op.a_sel = A_U; op.b_sel = B_UU; op.dst = D_W;
                                       op.idx = 2'd0; end
                        3'd3:    begin op.a_sel = A_T; op.b_sel = B_UU; op.dst = D_W3;
                                       op.idx = 2'd1; end
                        3'd4:    begin op.a_sel = A_U; op.b_sel = B_TT; op.dst = D_W3;
                                       op.idx = 2'd2; end
                        default: begin op.a_sel = A_T; op.b_sel = B_TT; op.dst = D_W;
                                       op.idx = 2'd3; end
                    endcase
                end
                default: begin
                    op.dst = D_W;
                    if (step[0]) begin
                        op.a_sel = A_T;
                        op.idx   = 2'd1;
                    end
                end
            endcase
        end else begin
            op.idx = k[3:2];
            case (k[1:0])
                2'd0:    begin op.a_sel = A_PX; op.b_sel = B_WLO; op.dst = D_ACCX_LO; end
                2'd1:    begin op.a_sel = A_PX; op.b_sel = B_WHI; op.dst = D_ACCX_HI; end
                2'd2:    begin op.a_sel = A_PY; op.b_sel = B_WLO; op.dst = D_ACCY_LO; end
                default: begin op.a_sel = A_PY; op.b_sel = B_WHI; op.dst = D_ACCY_HI; end
            endcase
            op.last = (k[3:2] == deg) && (k[1:0] == 2'd3);
        end
        return op;
    endfunction

endpackage

// File: hdl/bezier_path_tessellator_core.sv
// ============================================================================
// bezier_path_tessellator_core: Bezier path tessellator top level
// Joins the sequencer and the datapath behind the point and sample channels.
// ============================================================================
// Control points enter one per transaction; a point that does not complete a
// segment is absorbed while the sequencer stays idle. A point that
// completes a segment of the configured degree releases up to 64 samples,
// t stepping by t_step from zero and clamped to one. Each sample, whether
// linear, quadratic or cubic, runs a setup state, then the products on the
// single shared multiplier in turn (weights, then a low and a high partial
// product per coordinate and control point), a drain state and a rounding
// state. A sample waiting in the output register holds the run but does not
// stop the next point from being accepted once the run is done.
module bezier_path_tessellator_core
    import bpt_pkg::*;
#(
    parameter int COORD_BITS    = 16,
    parameter int T_FRAC_BITS   = 16,
    parameter int OUT_FRAC_BITS = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]                  cfg_addr,
    input  logic [T_FRAC_BITS:0]                   cfg_wr_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_start_path,
    input  logic signed [COORD_BITS-1:0]           s_point_x,
    input  logic signed [COORD_BITS-1:0]           s_point_y,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [COORD_BITS+OUT_FRAC_BITS-1:0] m_sample_x,
    output logic signed [COORD_BITS+OUT_FRAC_BITS-1:0] m_sample_y,
    output logic                                   m_last_of_segment
);

    bpt_cmd_t cmd;
    bpt_sts_t sts;

    bpt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bpt_datapath #(
        .COORD_BITS    (COORD_BITS),
        .T_FRAC_BITS   (T_FRAC_BITS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wr_data       (cfg_wr_data),
        .s_start_path      (s_start_path),
        .s_point_x         (s_point_x),
        .s_point_y         (s_point_y),
        .m_sample_x        (m_sample_x),
        .m_sample_y        (m_sample_y),
        .m_last_of_segment (m_last_of_segment),
        .cmd               (cmd),
        .sts               (sts)
    );

endmodule

// File: hdl/bpt_ctrl.sv
// ============================================================================
// bpt_ctrl: sequencer of the Bezier path tessellator
// Accepts control points, steps the shared multiplier through the weight and
// product sequence of each sample, and owns the result valid flag.
// ============================================================================
module bpt_ctrl
    import bpt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  bpt_sts_t sts,
    output bpt_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_DRAIN,
        ST_ROUND
    } state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    logic              m_valid_reg;
    mop_t              op;
    logic              accept;
    logic              load;

    always_comb begin
        op     = micro_op(sts.deg, step_reg);
        accept = s_valid && (state_reg == ST_IDLE);
        load   = (state_reg == ST_ROUND) && (!m_valid_reg || m_ready);
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign cmd.accept   = accept;
    assign cmd.setup    = (state_reg == ST_SETUP);
    assign cmd.op_valid = (state_reg == ST_MUL);
    assign cmd.op       = op;
    assign cmd.load_out = load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept && sts.seg_go) begin
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    step_reg  <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    if (op.last) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_ROUND;
                end
                ST_ROUND: begin
                    if (load) begin
                        state_reg <= sts.last_sample ? ST_IDLE : ST_SETUP;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_valid_from_round: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_ROUND))
        else $error("Result valid rose without a sample being loaded.");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (step_reg < STEP_W'(MAX_STEPS)))
        else $error("Micro-operation step ran past the longest sequence.");

    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && sts.last_sample) |=> (state_reg == ST_IDLE))
        else $error("Sequencer did not return to idle after the final sample.");

    a_hold_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !sts.seg_go) |=> (state_reg == ST_IDLE))
        else $error("A held point started a sample run.");
`endif

endmodule

// File: hdl/bpt_datapath.sv
// ============================================================================
// bpt_datapath: arithmetic and storage of the Bezier path tessellator
// Holds the configuration, the held points and the segment, and computes each
// sample as an exact Bernstein sum on one shared multiplier, rounded once.
// ============================================================================
module bpt_datapath
    import bpt_pkg::*;
#(
    parameter int COORD_BITS    = 16,
    parameter int T_FRAC_BITS   = 16,
    parameter int OUT_FRAC_BITS = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]                  cfg_addr,
    input  logic [T_FRAC_BITS:0]                   cfg_wr_data,
    input  logic                                   s_start_path,
    input  logic signed [COORD_BITS-1:0]           s_point_x,
    input  logic signed [COORD_BITS-1:0]           s_point_y,
    output logic signed [COORD_BITS+OUT_FRAC_BITS-1:0] m_sample_x,
    output logic signed [COORD_BITS+OUT_FRAC_BITS-1:0] m_sample_y,
    output logic                                   m_last_of_segment,
    input  bpt_cmd_t                               cmd,
    output bpt_sts_t                               sts
);

    localparam int TW    = T_FRAC_BITS + 1;
    localparam int TRW   = T_FRAC_BITS + 2;
    localparam int AW    = (COORD_BITS > TW) ? COORD_BITS : TW;
    localparam int BW    = 2 * T_FRAC_BITS + 1;
    localparam int WW    = 3 * T_FRAC_BITS + 1;
    localparam int PW    = AW + BW;
    localparam int ACC_W = 3 * T_FRAC_BITS + COORD_BITS;
    localparam int OW    = COORD_BITS + OUT_FRAC_BITS;
    localparam int EXT_W = ACC_W + OUT_FRAC_BITS;
    localparam int EPS   = ((1 << T_FRAC_BITS) + 5000) / 10000;

    localparam logic [TRW-1:0] T_ONE   = TRW'(1) << T_FRAC_BITS;
    localparam logic [TRW-1:0] T_LIMIT = T_ONE + TRW'(EPS);

    localparam int S1  = T_FRAC_BITS - OUT_FRAC_BITS;
    localparam int S2  = 2 * T_FRAC_BITS - OUT_FRAC_BITS;
    localparam int S3  = 3 * T_FRAC_BITS - OUT_FRAC_BITS;
    localparam int RS1 = (S1 > 0) ? S1 : 0;
    localparam int RS2 = (S2 > 0) ? S2 : 0;
    localparam int RS3 = (S3 > 0) ? S3 : 0;
    localparam int LS1 = (S1 > 0) ? 0 : -S1;
    localparam int LS2 = (S2 > 0) ? 0 : -S2;
    localparam int LS3 = (S3 > 0) ? 0 : -S3;
    localparam int RB1 = (S1 > 0) ? S1 - 1 : 0;
    localparam int RB2 = (S2 > 0) ? S2 - 1 : 0;
    localparam int RB3 = (S3 > 0) ? S3 - 1 : 0;
    localparam logic [ACC_W-1:0] BIAS1 = (S1 > 0) ? (ACC_W'(1) << RB1) : ACC_W'(0);
    localparam logic [ACC_W-1:0] BIAS2 = (S2 > 0) ? (ACC_W'(1) << RB2) : ACC_W'(0);
    localparam logic [ACC_W-1:0] BIAS3 = (S3 > 0) ? (ACC_W'(1) << RB3) : ACC_W'(0);

    logic [1:0]            deg_cfg_reg;
    logic [TW-1:0]         t_step_reg;
    logic [1:0]            held_count_reg;
    logic [COORD_BITS-1:0] held_x_reg [3];
    logic [COORD_BITS-1:0] held_y_reg [3];
    logic [COORD_BITS-1:0] px_reg [4];
    logic [COORD_BITS-1:0] py_reg [4];
    logic [1:0]            deg_reg;
    logic [TRW-1:0]        t_run_reg;
    logic [CNT_W-1:0]      n_reg;
    logic [TW-1:0]         tc_reg;
    logic [TW-1:0]         u_reg;
    logic [BW-1:0]         uu_reg;
    logic [BW-1:0]         tt_reg;
    logic [WW-1:0]         w_reg [4];
    logic [PW-1:0]         prod_reg;
    dst_t                  dst_reg;
    logic [1:0]            idx_reg;
    logic [ACC_W-1:0]      acc_x_reg;
    logic [ACC_W-1:0]      acc_y_reg;
    logic [OW-1:0]         sample_x_reg;
    logic [OW-1:0]         sample_y_reg;
    logic                  last_reg;

    logic [1:0]            deg_eff;
    logic [1:0]            count_eff;
    logic                  seg_go;
    logic [COORD_BITS-1:0] new_x;
    logic [COORD_BITS-1:0] new_y;
    logic [TRW-1:0]        t_next;
    logic                  last_sample;
    logic [TW-1:0]         t_clamp;
    logic [ACC_W-1:0]      bias;
    logic [AW-1:0]         a_opnd;
    logic [BW-1:0]         b_opnd;
    logic [EXT_W-1:0]      ext_x;
    logic [EXT_W-1:0]      ext_y;

    always_comb begin
        deg_eff     = (deg_cfg_reg == 2'd0) ? DEG_LINEAR : deg_cfg_reg;
        count_eff   = s_start_path ? 2'd0 : held_count_reg;
        seg_go      = (count_eff >= deg_eff);
        new_x       = {~s_point_x[COORD_BITS-1], s_point_x[COORD_BITS-2:0]};
        new_y       = {~s_point_y[COORD_BITS-1], s_point_y[COORD_BITS-2:0]};
        t_next      = t_run_reg + TRW'(t_step_reg);
        last_sample = (t_next > T_LIMIT) || (n_reg == CNT_W'(MAX_SAMPLES - 1));
        t_clamp     = (t_run_reg > T_ONE) ? T_ONE[TW-1:0] : t_run_reg[TW-1:0];
        case (deg_reg)
            DEG_QUADRATIC: bias = BIAS2;
            DEG_CUBIC:     bias = BIAS3;
            default:       bias = BIAS1;
        endcase
    end

    always_comb begin
        case (cmd.op.a_sel)
            A_U:     a_opnd = AW'(u_reg);
            A_T:     a_opnd = AW'(tc_reg);
            A_PX:    a_opnd = AW'(px_reg[cmd.op.idx]);
            default: a_opnd = AW'(py_reg[cmd.op.idx]);
        endcase
        case (cmd.op.b_sel)
            B_ONE:   b_opnd = BW'(1);
            B_U:     b_opnd = BW'(u_reg);
            B_T:     b_opnd = BW'(tc_reg);
            B_UU:    b_opnd = uu_reg;
            B_TT:    b_opnd = tt_reg;
            B_WLO:   b_opnd = w_reg[cmd.op.idx][BW-1:0];
            B_WHI:   b_opnd = BW'(w_reg[cmd.op.idx][WW-1:BW]);
            default: b_opnd = '0;
        endcase
    end

    always_comb begin
        case (deg_reg)
            DEG_QUADRATIC: begin
                ext_x = (EXT_W'(acc_x_reg) << LS2) >> RS2;
                ext_y = (EXT_W'(acc_y_reg) << LS2) >> RS2;
            end
            DEG_CUBIC: begin
                ext_x = (EXT_W'(acc_x_reg) << LS3) >> RS3;
                ext_y = (EXT_W'(acc_y_reg) << LS3) >> RS3;
            end
            default: begin
                ext_x = (EXT_W'(acc_x_reg) << LS1) >> RS1;
                ext_y = (EXT_W'(acc_y_reg) << LS1) >> RS1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deg_cfg_reg    <= CURVE_DEGREE_RESET;
            t_step_reg     <= TW'(T_STEP_RESET);
            held_count_reg <= 2'd0;
            deg_reg        <= DEG_LINEAR;
            dst_reg        <= D_NONE;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_CURVE_DEGREE: deg_cfg_reg <= cfg_wr_data[1:0];
                    CFG_T_STEP:       t_step_reg  <= cfg_wr_data;
                    default:          ;
                endcase
            end
            if (cmd.accept) begin
                if (seg_go) begin
                    held_count_reg <= 2'd1;
                    deg_reg        <= deg_eff;
                end else begin
                    held_count_reg <= count_eff + 2'd1;
                end
            end
            dst_reg <= cmd.op_valid ? cmd.op.dst : D_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            if (seg_go) begin
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) < deg_eff) begin
                        px_reg[i] <= held_x_reg[i];
                        py_reg[i] <= held_y_reg[i];
                    end
                end
                px_reg[deg_eff] <= new_x;
                py_reg[deg_eff] <= new_y;
                held_x_reg[0]   <= new_x;
                held_y_reg[0]   <= new_y;
                t_run_reg       <= '0;
                n_reg           <= '0;
            end else begin
                held_x_reg[count_eff] <= new_x;
                held_y_reg[count_eff] <= new_y;
            end
        end
        if (cmd.setup) begin
            tc_reg <= t_clamp;
            u_reg  <= T_ONE[TW-1:0] - t_clamp;
        end
        prod_reg <= PW'(a_opnd) * PW'(b_opnd);
        idx_reg  <= cmd.op.idx;
        if (cmd.setup) begin
            acc_x_reg <= bias;
            acc_y_reg <= bias;
        end else begin
            case (dst_reg)
                D_UU:      uu_reg <= prod_reg[BW-1:0];
                D_TT:      tt_reg <= prod_reg[BW-1:0];
                D_W:       w_reg[idx_reg] <= prod_reg[WW-1:0];
                D_W2:      w_reg[idx_reg] <= {prod_reg[WW-2:0], 1'b0};
                D_W3:      w_reg[idx_reg] <= prod_reg[WW-1:0] + {prod_reg[WW-2:0], 1'b0};
                D_ACCX_LO: acc_x_reg <= acc_x_reg + ACC_W'(prod_reg);
                D_ACCX_HI: acc_x_reg <= acc_x_reg + (ACC_W'(prod_reg) << BW);
                D_ACCY_LO: acc_y_reg <= acc_y_reg + ACC_W'(prod_reg);
                D_ACCY_HI: acc_y_reg <= acc_y_reg + (ACC_W'(prod_reg) << BW);
                default:   ;
            endcase
        end
        if (cmd.load_out) begin
            sample_x_reg <= {~ext_x[OW-1], ext_x[OW-2:0]};
            sample_y_reg <= {~ext_y[OW-1], ext_y[OW-2:0]};
            last_reg     <= last_sample;
            t_run_reg    <= t_next;
            n_reg        <= n_reg + CNT_W'(1);
        end
    end

    assign sts.seg_go         = seg_go;
    assign sts.deg            = deg_reg;
    assign sts.last_sample    = last_sample;
    assign m_sample_x         = sample_x_reg;
    assign m_sample_y         = sample_y_reg;
    assign m_last_of_segment  = last_reg;

endmodule

// File: tb/testbench.sv
// ============================================================================
// testbench: self-checking regression of bezier_path_tessellator_core
// Control points go in through the point channel; every curve sample that
// comes out is compared with a built-in model of the tessellator, which
// mirrors the configuration and keeps its own copy of the held points, or
// with typed samples in rows of a directed table that covers the corner
// cases; random paths under several degree, step and idle settings follow.
// ============================================================================
module testbench
    import bpt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW           = 16;
    localparam int TF           = 16;
    localparam int OF           = 8;
    localparam int OW           = CW + OF;
    localparam int T_ONE        = 1 << TF;
    localparam int T_EPS        = (T_ONE + 5000) / 10000;
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASE_ITEMS  = 17;
    localparam logic [CW-1:0] COORD_SIGN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic signed [OW-1:0] x;
        logic signed [OW-1:0] y;
        logic                 last;
    } sample_t;

    typedef enum logic {
        ROW_POINT,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_ADDR_W-1:0]  addr;
        logic [TF:0]            data;
        logic                   start;
        logic signed [CW-1:0]   x;
        logic signed [CW-1:0]   y;
        logic [1:0]             n_typed;
        sample_t                e0;
        sample_t                e1;
    } row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [TF:0]            cfg_wr_data;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_start_path;
    logic signed [CW-1:0]   s_point_x;
    logic signed [CW-1:0]   s_point_y;
    logic                   m_valid;
    logic                   m_ready;
    logic signed [OW-1:0]   m_sample_x;
    logic signed [OW-1:0]   m_sample_y;
    logic                   m_last_of_segment;

    sample_t              expected_samples[$];
    row_t                 plan[$];
    int                   errors;
    int                   tx_idle_pct;
    int                   rx_idle_pct;
    int                   hold_left;

    logic [1:0]           model_degree;
    logic [TF:0]          model_step;
    logic signed [CW-1:0] held_x[3];
    logic signed [CW-1:0] held_y[3];
    int                   held_count;

    bezier_path_tessellator_core #(
        .COORD_BITS   (CW),
        .T_FRAC_BITS  (TF),
        .OUT_FRAC_BITS(OF)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_start_path     (s_start_path),
        .s_point_x        (s_point_x),
        .s_point_y        (s_point_y),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sample_x       (m_sample_x),
        .m_sample_y       (m_sample_y),
        .m_last_of_segment(m_last_of_segment)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #10ms;
        $display("bezier_path_tessellator_core regression: fail");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        errors++;
    endtask

    function automatic void queue_sample(input sample_t s);
        expected_samples.insert(expected_samples.size(), s);
    endfunction

    function automatic void add_row(input row_t r);
        plan.insert(plan.size(), r);
    endfunction

    function automatic logic signed [OW-1:0] bezier_coord(input int deg,
                                                         input logic [3:0][CW-1:0] p,
                                                         input int t);
        logic [127:0] acc;
        logic [127:0] term;
        int           s;
        acc = '0;
        for (int i = 0; i <= deg; i++) begin
            term = (deg == 3 && (i == 1 || i == 2)) ? 128'd3 :
                   (deg == 2 && i == 1) ? 128'd2 : 128'd1;
            for (int k = 0; k < deg - i; k++) term = term * 128'(T_ONE - t);
            for (int k = 0; k < i; k++) term = term * 128'(t);
            term = term * 128'(p[i] ^ COORD_SIGN);
            acc  = acc + term;
        end
        s   = deg * TF - OF;
        acc = (acc + (128'd1 << (s - 1))) >> s;
        return OW'(acc - (128'd1 << (CW - 1 + OF)));
    endfunction

    // Updates the held points and returns the samples this point releases.
    function automatic int tessellate(input logic st, input logic signed [CW-1:0] x,
                                      input logic signed [CW-1:0] y,
                                      output sample_t run[MAX_SAMPLES]);
        int                  deg;
        int                  n;
        int                  t;
        int                  nxt;
        int                  tc;
        logic [3:0][CW-1:0]  bx;
        logic [3:0][CW-1:0]  by;
        deg = (model_degree == 2'd0) ? 1 : int'(model_degree);
        n   = 0;
        bx  = '0;
        by  = '0;
        if (st) held_count = 0;
        if (held_count >= deg) begin
            for (int i = 0; i < deg; i++) begin
                bx[i] = held_x[i];
                by[i] = held_y[i];
            end
            bx[deg] = x;
            by[deg] = y;
            t = 0;
            while (t <= T_ONE + T_EPS && n < MAX_SAMPLES) begin
                tc  = (t > T_ONE) ? T_ONE : t;
                nxt = t + int'(model_step);
                run[n].x    = bezier_coord(deg, bx, tc);
                run[n].y    = bezier_coord(deg, by, tc);
                run[n].last = (nxt > T_ONE + T_EPS) || (n == MAX_SAMPLES - 1);
                n++;
                t = nxt;
            end
            held_x[0]  = x;
            held_y[0]  = y;
            held_count = 1;
        end else begin
            held_x[held_count] = x;
            held_y[held_count] = y;
            held_count++;
        end
        return n;
    endfunction

    task automatic send_point(input logic st, input logic signed [CW-1:0] x,
                              input logic signed [CW-1:0] y, input int n_typed = 0,
                              input sample_t e0 = '0, input sample_t e1 = '0);
        sample_t run[MAX_SAMPLES];
        int      n;
        int      gap;
        gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_start_path <= st;
        s_point_x    <= x;
        s_point_y    <= y;
        do @(posedge aclk); while (!s_ready);
        n = tessellate(st, x, y, run);
        if (n_typed == 0) begin
            for (int i = 0; i < n; i++) queue_sample(run[i]);
        end else begin
            queue_sample(e0);
            if (n_typed > 1) queue_sample(e1);
        end
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [TF:0] data);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_samples.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= data;
        if (addr == CFG_CURVE_DEGREE) model_degree = data[1:0];
        else if (addr == CFG_T_STEP) model_step = data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic row_t point_row(input logic st, input logic signed [CW-1:0] x,
                                       input logic signed [CW-1:0] y,
                                       input logic [1:0] n_typed = 2'd0,
                                       input sample_t e0 = '0, input sample_t e1 = '0);
        row_t r;
        r         = '0;
        r.kind    = ROW_POINT;
        r.start   = st;
        r.x       = x;
        r.y       = y;
        r.n_typed = n_typed;
        r.e0      = e0;
        r.e1      = e1;
        return r;
    endfunction

    function automatic row_t cfg_row(input logic [CFG_ADDR_W-1:0] addr,
                                     input logic [TF:0] data);
        row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.addr = addr;
        r.data = data;
        return r;
    endfunction

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            default: return CW'($urandom);
        endcase
    endfunction

    always @(posedge aclk) begin : sample_check
        sample_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_samples.size() == 0) begin
                report_mismatch($sformatf("unexpected sample x=%0d y=%0d last=%0b",
                                          m_sample_x, m_sample_y, m_last_of_segment));
            end else begin
                want = expected_samples.pop_front();
                if (m_sample_x !== want.x)
                    report_mismatch($sformatf("sample_x %0d, expected %0d",
                                              m_sample_x, want.x));
                if (m_sample_y !== want.y)
                    report_mismatch($sformatf("sample_y %0d, expected %0d",
                                              m_sample_y, want.y));
                if (m_last_of_segment !== want.last)
                    report_mismatch($sformatf("last_of_segment %0b, expected %0b",
                                              m_last_of_segment, want.last));
            end
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        int       left;
        logic     st;
        int       deg;
        logic [TF:0] step;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = '0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_start_path = 1'b0;
        s_point_x    = '0;
        s_point_y    = '0;
        errors       = 0;
        hold_left    = 0;
        tx_idle_pct  = 10;
        rx_idle_pct  = 59;
        model_degree = CURVE_DEGREE_RESET;
        model_step   = (TF + 1)'(T_STEP_RESET);
        held_count   = 0;
        left         = 0;
        for (int i = 0; i < 3; i++) begin
            held_x[i] = '0;
            held_y[i] = '0;
        end

        add_row(point_row(1'b1, 16'sh8000, 16'sh8000));
        add_row(point_row(1'b0, 16'sh7fff, 16'sh7fff));
        add_row(cfg_row(CFG_T_STEP, 17'd65536));
        add_row(point_row(1'b1, 16'sh7fff, 16'sh8000));
        add_row(point_row(1'b0, 16'sh8000, 16'sh7fff, 2'd2,
                          '{x: 24'sd8388352, y: 24'sh800000, last: 1'b0},
                          '{x: 24'sh800000, y: 24'sd8388352, last: 1'b1}));
        add_row(point_row(1'b0, 16'sd0, 16'sd0));
        add_row(cfg_row(CFG_CURVE_DEGREE, 17'd0));
        add_row(point_row(1'b0, 16'sd1, -16'sd1));
        add_row(cfg_row(CFG_T_STEP, 17'h1ffff));
        add_row(point_row(1'b0, 16'sd5, 16'sd7, 2'd1,
                          '{x: 24'sd256, y: -24'sd256, last: 1'b1}));
        add_row(cfg_row(CFG_T_STEP, 17'd0));
        add_row(point_row(1'b0, -16'sd100, 16'sd200));
        add_row(cfg_row(CFG_T_STEP, 17'(T_ONE + T_EPS)));
        add_row(point_row(1'b0, 16'sh7fff, 16'sh8000));
        add_row(cfg_row(CFG_T_STEP, 17'(T_ONE + T_EPS + 1)));
        add_row(point_row(1'b0, -16'sd1, -16'sd1));
        add_row(cfg_row(CFG_CURVE_DEGREE, 17'(DEG_QUADRATIC)));
        add_row(cfg_row(CFG_T_STEP, 17'd16384));
        add_row(point_row(1'b1, 16'sh8000, 16'sh7fff));
        add_row(point_row(1'b0, 16'sh7fff, 16'sh8000));
        add_row(point_row(1'b0, 16'sh8000, 16'sh7fff));
        add_row(point_row(1'b0, -16'sd1234, 16'sd4321));
        add_row(point_row(1'b1, 16'sd100, 16'sd100));
        add_row(cfg_row(CFG_CURVE_DEGREE, 17'(DEG_CUBIC)));
        add_row(cfg_row(CFG_T_STEP, 17'd1025));
        add_row(point_row(1'b0, 16'sh7fff, 16'sh7fff));
        add_row(point_row(1'b0, 16'sh8000, 16'sh8000));
        add_row(point_row(1'b0, 16'sh7fff, 16'sh8000));
        add_row(point_row(1'b0, 16'sd7, -16'sd7));
        add_row(point_row(1'b0, -16'sd300, 16'sd300));
        add_row(cfg_row(CFG_CURVE_DEGREE, 17'(DEG_LINEAR)));
        add_row(point_row(1'b0, 16'sd1000, -16'sd1000));
        add_row(cfg_row(CFG_CURVE_DEGREE, 17'(DEG_CUBIC)));
        add_row(cfg_row(CFG_T_STEP, 17'd8192));
        add_row(point_row(1'b1, 16'sd0, 16'sd0));
        add_row(point_row(1'b0, 16'sd1, 16'sd1));
        add_row(cfg_row(CFG_CURVE_DEGREE, 17'(DEG_QUADRATIC)));
        add_row(cfg_row(CFG_UNMAPPED, 17'h1ffff));
        add_row(point_row(1'b0, 16'sd2, 16'sd2));
        add_row(cfg_row(CFG_CURVE_DEGREE, 17'(DEG_CUBIC)));
        add_row(point_row(1'b1, 16'sd9, 16'sd9));
        add_row(point_row(1'b0, 16'sd10, 16'sd10));

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG)
                write_reg(plan[i].addr, plan[i].data);
            else
                send_point(plan[i].start, plan[i].x, plan[i].y, int'(plan[i].n_typed),
                           plan[i].e0, plan[i].e1);
        end

        for (int ph = 0; ph < 6; ph++) begin
            tx_idle_pct = (ph < 2) ? 10 : (ph < 4) ? 59 : 0;
            rx_idle_pct = (ph < 2) ? 59 : (ph < 4) ? 10 : 0;
            deg = (ph + 1) % 4;
            case (ph)
                0:       step = 17'd1025;
                1:       step = 17'($urandom_range(1025, T_ONE));
                2:       step = 17'(T_ONE);
                3:       step = 17'($urandom_range(2048, 16384));
                4:       step = 17'd0;
                default: step = 17'($urandom_range(T_ONE + 1, 131071));
            endcase
            write_reg(CFG_CURVE_DEGREE, 17'(deg));
            write_reg(CFG_T_STEP, step);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (left == 0) begin
                    st   = 1'b1;
                    left = $urandom_range(2, 9);
                end else begin
                    st = ($urandom_range(19) == 0);
                end
                left--;
                send_point(st, rand_coord(), rand_coord());
                if (ph == 1 && k == 3) hold_left = 400;
            end
        end

        @(negedge aclk);
        s_valid     <= 1'b0;
        rx_idle_pct = 0;
        for (int k = 0; k < 200000 && expected_samples.size() != 0; k++) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (expected_samples.size() != 0)
            report_mismatch($sformatf("%0d expected samples never arrived",
                                      expected_samples.size()));

        if (errors == 0)
            $display("bezier_path_tessellator_core regression: pass");
        else
            $display("bezier_path_tessellator_core regression: fail");
        $finish;
    end

endmodule

// File: sim.f
hdl/bpt_pkg.sv
hdl/bpt_ctrl.sv
hdl/bpt_datapath.sv
hdl/bezier_path_tessellator_core.sv
tb/testbench.sv
